>>> src/prc_pkg.sv
// Package for the polar/rectangular converter: widths, fixed-point constants,
// the work-word type shared by the front end, the queue and the CORDIC pipeline.
// No dependencies.
package prc_pkg;

    // Port widths
    localparam int DATA_WIDTH = 16;
    localparam int RES_W      = DATA_WIDTH + 1;
    localparam int ITERATIONS = 16;

    // Fixed-point layout
    localparam int GUARD      = 8;
    localparam int ANG_FRAC   = DATA_WIDTH - 3;
    localparam int ANG_SHIFT  = 30 - ANG_FRAC;
    localparam int GAIN_SHIFT = 30 - GUARD;
    localparam int OP_W       = DATA_WIDTH + 1;
    localparam int GAIN_W     = 31;
    localparam int PROD_W     = OP_W + GAIN_W;
    // x/y datapath: scaled operand plus CORDIC growth headroom
    localparam int XY_W       = PROD_W - GAIN_SHIFT;
    // Q30 angle with room for pi plus the atan sum and the reduction offsets
    localparam int Z_W        = 35;

    // Command codes
    localparam logic CMD_TO_POLAR = 1'b0;
    localparam logic CMD_TO_RECT  = 1'b1;

    // Angle constants, Q30 radians
    localparam longint PI_Q30_L      = 64'sd3373259426;
    localparam longint HALF_PI_Q30_L = 64'sd1686629713;
    localparam logic signed [Z_W-1:0] PI_Q30      = Z_W'(PI_Q30_L);
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(HALF_PI_Q30_L);

    // Same angles at the port scale (rounded)
    localparam longint PI_A_L  = (PI_Q30_L + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    localparam longint HPI_A_L = (HALF_PI_Q30_L + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;

    // CORDIC gain compensation, 0.6072529350 in Q30
    localparam logic signed [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(64'sd652032874);

    // Decoupling queue between front end and pipeline (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified word, before gain scaling
    typedef struct packed {
        logic                   cmd;
        logic                   bypass;
        logic signed [OP_W-1:0] op_x;
        logic signed [OP_W-1:0] op_y;
        logic signed [Z_W-1:0]  z;
    } prc_front_t;

    // Work word carried through the queue and the CORDIC stages.
    // For bypass words x and y hold the final results.
    typedef struct packed {
        logic                   cmd;
        logic                   bypass;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } prc_work_t;

    // atan(2^-i) in Q30, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = Z_W'(64'sd843314857);
            1:  v = Z_W'(64'sd497837829);
            2:  v = Z_W'(64'sd263043837);
            3:  v = Z_W'(64'sd133525159);
            4:  v = Z_W'(64'sd67021687);
            5:  v = Z_W'(64'sd33543516);
            6:  v = Z_W'(64'sd16775851);
            7:  v = Z_W'(64'sd8388437);
            8:  v = Z_W'(64'sd4194283);
            9:  v = Z_W'(64'sd2097149);
            10: v = Z_W'(64'sd1048576);
            11: v = Z_W'(64'sd524288);
            12: v = Z_W'(64'sd262144);
            13: v = Z_W'(64'sd131072);
            14: v = Z_W'(64'sd65536);
            15: v = Z_W'(64'sd32768);
            16: v = Z_W'(64'sd16384);
            17: v = Z_W'(64'sd8192);
            18: v = Z_W'(64'sd4096);
            19: v = Z_W'(64'sd2048);
            20: v = Z_W'(64'sd1024);
            21: v = Z_W'(64'sd512);
            22: v = Z_W'(64'sd256);
            23: v = Z_W'(64'sd128);
            24: v = Z_W'(64'sd64);
            25: v = Z_W'(64'sd32);
            26: v = Z_W'(64'sd16);
            27: v = Z_W'(64'sd8);
            28: v = Z_W'(64'sd4);
            29: v = Z_W'(64'sd2);
            30: v = Z_W'(64'sd1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/prc_if.sv
// Valid/ready channel interfaces of the polar/rectangular converter:
// the request channel and the response channel.
// Depends on prc_pkg.
interface prc_req_if;
    import prc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic signed [DATA_WIDTH-1:0] first_operand;
    logic signed [DATA_WIDTH-1:0] second_operand;

    modport source (output valid, output cmd, output first_operand,
                    output second_operand, input ready);
    modport sink   (input valid, input cmd, input first_operand,
                    input second_operand, output ready);
endinterface

interface prc_rsp_if;
    import prc_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [RES_W-1:0]      first_result;
    logic signed [DATA_WIDTH-1:0] second_result;

    modport source (output valid, output first_result, output second_result,
                    input ready);
    modport sink   (input valid, input first_result, input second_result,
                    output ready);
endinterface

>>> src/prc_front.sv
// Front end: accepts request words, resolves special cases, folds the
// operands into the CORDIC range and applies the gain compensation.
// Depends on prc_pkg and prc_if.
module prc_front (
    input  logic                clk,
    input  logic                rst_n,
    prc_req_if.sink             request,
    output logic                push_valid,
    input  logic                push_ready,
    output prc_pkg::prc_work_t  push_data
);
    import prc_pkg::*;

    // Angle reduction constants (Q30)
    localparam longint TWO_PI_L = 2 * PI_Q30_L;
    localparam logic signed [Z_W-1:0] TH_GT_HI = Z_W'(HALF_PI_Q30_L + TWO_PI_L);
    localparam logic signed [Z_W-1:0] TH_GT_LO = Z_W'(HALF_PI_Q30_L - TWO_PI_L);
    localparam logic signed [Z_W-1:0] TH_LT_HI = Z_W'(-HALF_PI_Q30_L + TWO_PI_L);
    localparam logic signed [Z_W-1:0] TH_LT_LO = Z_W'(-HALF_PI_Q30_L - TWO_PI_L);
    localparam logic signed [Z_W-1:0] NEG_PI   = Z_W'(-PI_Q30_L);
    localparam logic signed [Z_W-1:0] NEG_HPI  = Z_W'(-HALF_PI_Q30_L);
    localparam logic signed [Z_W-1:0] OFF_M3PI = Z_W'(-3 * PI_Q30_L);
    localparam logic signed [Z_W-1:0] OFF_M2PI = Z_W'(-TWO_PI_L);
    localparam logic signed [Z_W-1:0] OFF_P2PI = Z_W'(TWO_PI_L);
    localparam logic signed [Z_W-1:0] OFF_P3PI = Z_W'(3 * PI_Q30_L);

    // Port-scale angles for the special cases
    localparam logic signed [OP_W-1:0] PI_A_OP      = OP_W'(PI_A_L);
    localparam logic signed [OP_W-1:0] HPI_A_OP     = OP_W'(HPI_A_L);
    localparam logic signed [OP_W-1:0] NEG_HPI_A_OP = OP_W'(-HPI_A_L);

    // Rounding constant for the gain product
    localparam logic signed [PROD_W-1:0] GAIN_RND = PROD_W'(64'sd1 <<< (GAIN_SHIFT - 1));

    logic signed [OP_W-1:0] a_ext;
    logic signed [OP_W-1:0] b_ext;
    logic signed [Z_W-1:0]  b_ang;
    logic                   a_zero;
    logic                   b_zero;
    logic                   a_neg;
    logic                   b_neg;
    logic                   red_hi;
    logic                   red_lo;
    logic                   fold_gt;
    logic                   fold_lt;
    logic signed [Z_W-1:0]  th_gt;
    logic signed [Z_W-1:0]  th_lt;
    logic signed [Z_W-1:0]  ang_off;

    prc_front_t             fr_next;
    prc_front_t             fr_reg;
    logic                   fr_valid_reg;
    logic                   fr_valid_next;

    logic signed [OP_W-1:0]   op_x_s;
    logic signed [OP_W-1:0]   op_y_s;
    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] sum_x;
    logic signed [PROD_W-1:0] sum_y;

    // Operand views
    assign a_ext  = OP_W'(request.first_operand);
    assign b_ext  = OP_W'(request.second_operand);
    assign b_ang  = Z_W'(request.second_operand) <<< ANG_SHIFT;
    assign a_zero = (request.first_operand == '0);
    assign b_zero = (request.second_operand == '0);
    assign a_neg  = request.first_operand[DATA_WIDTH-1];
    assign b_neg  = request.second_operand[DATA_WIDTH-1];

    // Input angle: wrap by 2pi, then fold into [-pi/2, pi/2] (all compares in parallel)
    assign red_hi  = (b_ang > PI_Q30);
    assign red_lo  = (b_ang < NEG_PI);
    assign th_gt   = red_hi ? TH_GT_HI : (red_lo ? TH_GT_LO : HALF_PI_Q30);
    assign th_lt   = red_hi ? TH_LT_HI : (red_lo ? TH_LT_LO : NEG_HPI);
    assign fold_gt = (b_ang > th_gt);
    assign fold_lt = !fold_gt && (b_ang < th_lt);

    always_comb
    begin
        if (red_hi)
        begin
            ang_off = fold_gt ? OFF_M3PI : (fold_lt ? NEG_PI : OFF_M2PI);
        end
        else if (red_lo)
        begin
            ang_off = fold_gt ? PI_Q30 : (fold_lt ? OFF_P3PI : OFF_P2PI);
        end
        else
        begin
            ang_off = fold_gt ? NEG_PI : (fold_lt ? PI_Q30 : '0);
        end
    end

    // Classification
    always_comb
    begin
        fr_next        = '0;
        fr_next.cmd    = request.cmd;
        if (request.cmd == CMD_TO_POLAR)
        begin
            if (a_zero && b_zero)
            begin
                fr_next.bypass = 1'b1;
            end
            else if (a_zero)
            begin
                // on the y axis
                fr_next.bypass = 1'b1;
                fr_next.op_x   = b_neg ? -b_ext : b_ext;
                fr_next.op_y   = b_neg ? NEG_HPI_A_OP : HPI_A_OP;
            end
            else if (b_zero)
            begin
                // on the x axis
                fr_next.bypass = 1'b1;
                fr_next.op_x   = a_neg ? -a_ext : a_ext;
                fr_next.op_y   = a_neg ? PI_A_OP : '0;
            end
            else if (a_neg)
            begin
                // left half plane: turn by 180 degrees, start at +-pi
                fr_next.op_x = -a_ext;
                fr_next.op_y = -b_ext;
                fr_next.z    = b_neg ? NEG_PI : PI_Q30;
            end
            else
            begin
                fr_next.op_x = a_ext;
                fr_next.op_y = b_ext;
            end
        end
        else
        begin
            // rotation: folded angle flips the magnitude
            fr_next.op_x = (fold_gt || fold_lt) ? -a_ext : a_ext;
            fr_next.z    = b_ang + ang_off;
        end
    end

    // Front register handshake
    assign request.ready = !fr_valid_reg || push_ready;

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (request.ready)
        begin
            fr_valid_next = request.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
        begin
            fr_reg <= fr_next;
        end
    end

    // Gain compensation: round(v * K / 2^(30-G))
    assign op_x_s = fr_reg.op_x;
    assign op_y_s = fr_reg.op_y;
    assign prod_x = op_x_s * GAIN_Q30;
    assign prod_y = op_y_s * GAIN_Q30;
    assign sum_x  = prod_x + GAIN_RND;
    assign sum_y  = prod_y + GAIN_RND;

    always_comb
    begin
        push_data.cmd    = fr_reg.cmd;
        push_data.bypass = fr_reg.bypass;
        push_data.z      = fr_reg.z;
        if (fr_reg.bypass)
        begin
            push_data.x = XY_W'(op_x_s);
            push_data.y = XY_W'(op_y_s);
        end
        else
        begin
            push_data.x = sum_x[PROD_W-1 -: XY_W];
            push_data.y = sum_y[PROD_W-1 -: XY_W];
        end
    end

    assign push_valid = fr_valid_reg;

endmodule

>>> src/prc_queue.sv
// Short FIFO between the front end and the CORDIC pipeline, so that each
// side can stall on its own. Depends on prc_pkg.
module prc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  prc_pkg::prc_work_t  push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output prc_pkg::prc_work_t  pop_data
);
    import prc_pkg::*;

    prc_work_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update (pointers wrap at the power-of-two depth)
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/prc_back.sv
// Back end: pipelined CORDIC (one stage per iteration, vectoring or rotation
// per word), then rounding and saturation into the output register.
// Depends on prc_pkg and prc_if.
module prc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  prc_pkg::prc_work_t  pop_data,
    prc_rsp_if.source           response
);
    import prc_pkg::*;

    localparam int RX_W = XY_W + 1 - GUARD;
    localparam int ZR_W = Z_W + 1 - ANG_SHIFT;

    localparam logic signed [XY_W:0] XY_RND = (XY_W + 1)'(64'sd1 <<< (GUARD - 1));
    localparam logic signed [Z_W:0]  Z_RND  = (Z_W + 1)'(64'sd1 <<< (ANG_SHIFT - 1));

    localparam logic signed [RX_W-1:0] MAG_MAX = RX_W'((64'sd1 <<< DATA_WIDTH) - 1);
    localparam logic signed [RX_W-1:0] S_MAX   = RX_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [RX_W-1:0] S_MIN   = RX_W'(-(64'sd1 <<< (DATA_WIDTH - 1)));
    localparam logic signed [ZR_W-1:0] ANG_MAX = ZR_W'(PI_A_L);
    localparam logic signed [ZR_W-1:0] ANG_MIN = ZR_W'(1 - PI_A_L);

    // One micro-rotation; shift amount is a constant per stage
    function automatic prc_work_t cordic_step(input prc_work_t s, input int unsigned sh);
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [Z_W-1:0]  zs;
        logic signed [Z_W-1:0]  ang;
        logic                   ccw;
        prc_work_t              r;
        xs  = s.x;
        ys  = s.y;
        zs  = s.z;
        dx  = xs >>> sh;
        dy  = ys >>> sh;
        ang = atan_q30(sh);
        // rotation follows the residual angle, vectoring drives y to zero
        ccw = (s.cmd == CMD_TO_RECT) ? !zs[Z_W-1] : ys[XY_W-1];
        r   = s;
        if (!s.bypass)
        begin
            if (ccw)
            begin
                r.x = xs - dy;
                r.y = ys + dx;
                r.z = zs - ang;
            end
            else
            begin
                r.x = xs + dy;
                r.y = ys - dx;
                r.z = zs + ang;
            end
        end
        return r;
    endfunction

    prc_work_t                st_reg [ITERATIONS+1];
    logic [ITERATIONS:0]      st_valid_reg;
    logic [ITERATIONS:0]      st_valid_next;
    prc_work_t                step_next [ITERATIONS];
    logic                     back_adv;

    prc_work_t                fin;
    logic signed [XY_W-1:0]   fin_x;
    logic signed [XY_W-1:0]   fin_y;
    logic signed [Z_W-1:0]    fin_z;
    logic signed [XY_W:0]     rx_sum;
    logic signed [XY_W:0]     ry_sum;
    logic signed [Z_W:0]      rz_sum;
    logic signed [RX_W-1:0]   rx;
    logic signed [RX_W-1:0]   ry;
    logic signed [ZR_W-1:0]   rz;
    logic signed [RX_W-1:0]   r0_sat;
    logic signed [RX_W-1:0]   r1_sat;
    logic signed [ZR_W-1:0]   ang_sat;
    logic signed [RES_W-1:0]      first_next;
    logic signed [DATA_WIDTH-1:0] second_next;

    logic                         out_valid_reg;
    logic signed [RES_W-1:0]      first_reg;
    logic signed [DATA_WIDTH-1:0] second_reg;

    // The whole pipeline moves unless a finished word waits at the output
    assign back_adv  = !out_valid_reg || response.ready;
    assign pop_ready = back_adv;

    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_stage
        assign step_next[g] = cordic_step(st_reg[g], g);
    end

    // Valid bits
    assign st_valid_next = {st_valid_reg[ITERATIONS-1:0], pop_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= st_valid_reg[ITERATIONS];
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            st_reg[0] <= pop_data;
            for (int i = 0; i < ITERATIONS; i++)
            begin
                st_reg[i+1] <= step_next[i];
            end
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    // Drop guard bits with rounding, then saturate
    assign fin    = st_reg[ITERATIONS];
    assign fin_x  = fin.x;
    assign fin_y  = fin.y;
    assign fin_z  = fin.z;
    assign rx_sum = (XY_W + 1)'(fin_x) + XY_RND;
    assign ry_sum = (XY_W + 1)'(fin_y) + XY_RND;
    assign rz_sum = (Z_W + 1)'(fin_z) + Z_RND;
    assign rx     = rx_sum[XY_W:GUARD];
    assign ry     = ry_sum[XY_W:GUARD];
    assign rz     = rz_sum[Z_W:ANG_SHIFT];

    always_comb
    begin
        if (fin.cmd == CMD_TO_RECT)
        begin
            r0_sat = (rx > S_MAX) ? S_MAX : ((rx < S_MIN) ? S_MIN : rx);
        end
        else
        begin
            r0_sat = (rx > MAG_MAX) ? MAG_MAX : ((rx < 0) ? '0 : rx);
        end
        r1_sat  = (ry > S_MAX) ? S_MAX : ((ry < S_MIN) ? S_MIN : ry);
        ang_sat = (rz > ANG_MAX) ? ANG_MAX : ((rz < ANG_MIN) ? ANG_MIN : rz);
    end

    // Result select
    always_comb
    begin
        if (fin.bypass)
        begin
            first_next  = fin_x[RES_W-1:0];
            second_next = fin_y[DATA_WIDTH-1:0];
        end
        else if (fin.cmd == CMD_TO_RECT)
        begin
            first_next  = r0_sat[RES_W-1:0];
            second_next = r1_sat[DATA_WIDTH-1:0];
        end
        else
        begin
            first_next  = r0_sat[RES_W-1:0];
            second_next = ang_sat[DATA_WIDTH-1:0];
        end
    end

    assign response.valid         = out_valid_reg;
    assign response.first_result  = first_reg;
    assign response.second_result = second_reg;

endmodule

>>> src/polar_rect_converter.sv
// Top level of the polar/rectangular converter: front end, decoupling queue
// and CORDIC pipeline. Depends on prc_pkg, prc_if, prc_front, prc_queue, prc_back.
//
// Usage:
//   request  (valid/ready): cmd, first_operand, second_operand. cmd = 0 turns
//            (x, y) into (magnitude, angle); cmd = 1 turns (magnitude, angle)
//            into (x, y). Angles are Q3.13 radians.
//   response (valid/ready): first_result, second_result, one word per request,
//            in request order.
//   Path:    a word passes through 1 front register, 1 queue slot, 17 CORDIC
//            stage registers for 16 iterations and 1 output register.
//   Throughput: one word per cycle while response.ready does not stall it;
//            the 16-stage CORDIC pipeline does one shift-add iteration per stage.
//   Stall: while a result waits on response.ready the CORDIC pipeline holds;
//            the front end keeps accepting until its register and the 4-entry
//            queue are full, then drops request.ready. Up to 23 words can be
//            in flight.
//   Reset: rst_n is asynchronous, active low; it empties the pipeline, the
//            queue and the front register. No state survives between words.
module polar_rect_converter (
    input  logic      clk,
    input  logic      rst_n,
    prc_req_if.sink   request,
    prc_rsp_if.source response
);
    import prc_pkg::*;

    logic       push_valid;
    logic       push_ready;
    prc_work_t  push_data;
    logic       pop_valid;
    logic       pop_ready;
    prc_work_t  pop_data;

    // Classify and scale
    prc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decoupling queue
    prc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // CORDIC pipeline and output register
    prc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .response   (response)
    );

endmodule

>>> src/prc_checker.sv
// Port-level checker for the polar/rectangular converter, bound to the top
// level. Depends on prc_pkg and polar_rect_converter.
module prc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [prc_pkg::RES_W-1:0]     first_result,
    input logic signed [prc_pkg::DATA_WIDTH-1:0] second_result
);
    import prc_pkg::*;

    // Front register + queue + stage registers + output register
    localparam int CAPACITY = 1 + QUEUE_DEPTH + (ITERATIONS + 1) + 1;
    localparam int OCC_W    = $clog2(CAPACITY + 1) + 1;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Words accepted but not yet delivered
    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc && !out_acc)
        begin
            occ_next = occ_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_result)
                                    && $stable(second_result))
        else $error("response word changed while stalled");

    // No result without a request in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
        else $error("response word with no request outstanding");

    // In-flight words never exceed the storage of the block
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("more words in flight than the block can hold");

    // An empty block accepts
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == '0 |-> in_ready)
        else $error("empty block not ready for a request");

endmodule

bind polar_rect_converter prc_checker u_prc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (request.valid),
    .in_ready      (request.ready),
    .out_valid     (response.valid),
    .out_ready     (response.ready),
    .first_result  (response.first_result),
    .second_result (response.second_result)
);

>>> tb/tb_polar_rect_converter.sv
`timescale 1ns / 100ps
// Self-checking testbench for polar_rect_converter: directed table, then random words, each
// checked against its typed row or a bit-exact CORDIC model. Depends on prc_pkg and prc_if.
module tb_polar_rect_converter;
    import prc_pkg::*;

    // Fixed-point layout of the conversion
    localparam int     GUARD_BITS      = 8;
    localparam int     PORT_ANG_SHIFT  = 30 - (DATA_WIDTH - 3);
    localparam longint ANG_PI_Q30      = 64'sd3373259426;
    localparam longint ANG_HALF_PI_Q30 = 64'sd1686629713;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint PI_PORT =
        (ANG_PI_Q30 + (64'sd1 <<< (PORT_ANG_SHIFT - 1))) >>> PORT_ANG_SHIFT;
    localparam longint HALF_PI_PORT =
        (ANG_HALF_PI_Q30 + (64'sd1 <<< (PORT_ANG_SHIFT - 1))) >>> PORT_ANG_SHIFT;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_WORDS  = 1625;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RUN_LIMIT_NS  = 5_000_000;

    typedef struct packed {
        logic                         cmd;
        logic signed [DATA_WIDTH-1:0] op_a;
        logic signed [DATA_WIDTH-1:0] op_b;
    } conv_req_t;

    typedef struct packed {
        logic signed [RES_W-1:0]      first_result;
        logic signed [DATA_WIDTH-1:0] second_result;
    } conv_result_t;

    typedef struct {
        conv_req_t    req;
        conv_result_t res;
    } pending_t;

    // typed = 1: expected words are written in the row, else predicted
    typedef struct {
        logic cmd;
        int   op_a;
        int   op_b;
        bit   typed;
        int   exp_first;
        int   exp_second;
    } directed_row_t;

    logic clk;
    logic rst_n;
    int   error_count;
    int   burst_left;

    pending_t pending_results[$];

    // atan(2^-i), Q30
    longint atan_steps [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    directed_row_t directed_table [DIRECTED_ROWS] = '{
        // zero vector, axis points and full-scale axis extremes
        '{CMD_TO_POLAR,      0,      0, 1'b1,     0,      0},
        '{CMD_TO_POLAR,      0,  32767, 1'b1, 32767,  12868},
        '{CMD_TO_POLAR,      0, -32768, 1'b1, 32768, -12868},
        '{CMD_TO_POLAR,  32767,      0, 1'b1, 32767,      0},
        '{CMD_TO_POLAR, -32768,      0, 1'b1, 32768,  25736},
        '{CMD_TO_POLAR,     -1,      0, 1'b1,     1,  25736},
        '{CMD_TO_POLAR,      0,      1, 1'b1,     1,  12868},
        // largest magnitude, left half plane, angle clamp near +/-pi
        '{CMD_TO_POLAR,  32767,  32767, 1'b0,     0,      0},
        '{CMD_TO_POLAR, -32768, -32768, 1'b0,     0,      0},
        '{CMD_TO_POLAR, -32768,      1, 1'b0,     0,      0},
        '{CMD_TO_POLAR, -32768,     -1, 1'b0,     0,      0},
        '{CMD_TO_POLAR,      1,      1, 1'b0,     0,      0},
        '{CMD_TO_POLAR,     -1,      1, 1'b0,     0,      0},
        '{CMD_TO_POLAR,      1,     -1, 1'b0,     0,      0},
        // rotation: zero, saturation, negative magnitude, wrap and fold
        '{CMD_TO_RECT,       0,      0, 1'b1,     0,      0},
        '{CMD_TO_RECT,   32767,      0, 1'b0,     0,      0},
        '{CMD_TO_RECT,  -32768,      0, 1'b0,     0,      0},
        '{CMD_TO_RECT,   32767,  32767, 1'b0,     0,      0},
        '{CMD_TO_RECT,   32767, -32768, 1'b0,     0,      0},
        '{CMD_TO_RECT,   32767,  12868, 1'b0,     0,      0},
        '{CMD_TO_RECT,   32767,  12869, 1'b0,     0,      0},
        '{CMD_TO_RECT,  -32768, -12869, 1'b0,     0,      0},
        '{CMD_TO_RECT,   32767,  25736, 1'b0,     0,      0},
        '{CMD_TO_RECT,   32767,  25737, 1'b0,     0,      0},
        '{CMD_TO_RECT,  -32768, -25737, 1'b0,     0,      0}
    };

    prc_req_if req_ch ();
    prc_rsp_if rsp_ch ();

    polar_rect_converter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch),
        .response (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Round half up, then floor shift
    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Bit-exact CORDIC conversion of one request word
    function automatic conv_result_t convert_word(conv_req_t req);
        longint a, b, x, y, z, dx, dy, r0, r1, smin, smax;
        conv_result_t res;
        a    = $signed(req.op_a);
        b    = $signed(req.op_b);
        smin = -(64'sd1 <<< (DATA_WIDTH - 1));
        smax = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
        if (req.cmd == CMD_TO_POLAR)
        begin
            if (a == 0 && b == 0)
            begin
                r0 = 0;
                r1 = 0;
            end
            else if (a == 0)
            begin
                r0 = (b > 0) ? b : -b;
                r1 = (b > 0) ? HALF_PI_PORT : -HALF_PI_PORT;
            end
            else if (b == 0)
            begin
                r0 = (a > 0) ? a : -a;
                r1 = (a > 0) ? 0 : PI_PORT;
            end
            else
            begin
                x = a;
                y = b;
                z = 0;
                // left half plane: turn by 180 degrees first
                if (x < 0)
                begin
                    z = (y > 0) ? ANG_PI_Q30 : -ANG_PI_Q30;
                    x = -x;
                    y = -y;
                end
                x = round_shift(x * CORDIC_GAIN_Q30, 30 - GUARD_BITS);
                y = round_shift(y * CORDIC_GAIN_Q30, 30 - GUARD_BITS);
                for (int i = 0; i < ITERATIONS; i++)
                begin
                    dx = x >>> i;
                    dy = y >>> i;
                    if (y >= 0)
                    begin
                        x += dy;
                        y -= dx;
                        z += atan_steps[i];
                    end
                    else
                    begin
                        x -= dy;
                        y += dx;
                        z -= atan_steps[i];
                    end
                end
                r0 = clamp(round_shift(x, GUARD_BITS), 0, (64'sd1 <<< DATA_WIDTH) - 1);
                r1 = clamp(round_shift(z, PORT_ANG_SHIFT), -PI_PORT + 1, PI_PORT);
            end
        end
        else
        begin
            z = b * (64'sd1 <<< PORT_ANG_SHIFT);
            y = 0;
            // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
            if (z > ANG_PI_Q30)
                z -= 2 * ANG_PI_Q30;
            else if (z < -ANG_PI_Q30)
                z += 2 * ANG_PI_Q30;
            if (z > ANG_HALF_PI_Q30)
            begin
                z -= ANG_PI_Q30;
                a = -a;
            end
            else if (z < -ANG_HALF_PI_Q30)
            begin
                z += ANG_PI_Q30;
                a = -a;
            end
            x = round_shift(a * CORDIC_GAIN_Q30, 30 - GUARD_BITS);
            for (int i = 0; i < ITERATIONS; i++)
            begin
                dx = x >>> i;
                dy = y >>> i;
                if (z >= 0)
                begin
                    x -= dy;
                    y += dx;
                    z -= atan_steps[i];
                end
                else
                begin
                    x += dy;
                    y -= dx;
                    z += atan_steps[i];
                end
            end
            r0 = clamp(round_shift(x, GUARD_BITS), smin, smax);
            r1 = clamp(round_shift(y, GUARD_BITS), smin, smax);
        end
        res.first_result  = RES_W'(r0);
        res.second_result = DATA_WIDTH'(r1);
        return res;
    endfunction

    // Zero, extremes, tiny values or anything
    function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return {1'b0, {(DATA_WIDTH - 1){1'b1}}};
            2: return {1'b1, {(DATA_WIDTH - 1){1'b0}}};
            3: return DATA_WIDTH'(int'($urandom_range(0, 8)) - 4);
            default: return DATA_WIDTH'($urandom());
        endcase
    endfunction

    // Angle close to 0, +/-pi/2 or +/-pi
    function automatic logic signed [DATA_WIDTH-1:0] pick_boundary_angle();
        longint base;
        case ($urandom_range(0, 4))
            0: base = 0;
            1: base = HALF_PI_PORT;
            2: base = -HALF_PI_PORT;
            3: base = PI_PORT;
            default: base = -PI_PORT;
        endcase
        return DATA_WIDTH'(base + int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic conv_req_t random_request();
        conv_req_t r;
        int unsigned kind;
        kind   = $urandom_range(0, 99);
        r.cmd  = $urandom_range(0, 1) ? CMD_TO_RECT : CMD_TO_POLAR;
        r.op_a = DATA_WIDTH'($urandom());
        r.op_b = DATA_WIDTH'($urandom());
        if (kind < 20)
        begin
            // polar with an axis point or tiny coordinate
            r.cmd = CMD_TO_POLAR;
            if ($urandom_range(0, 1))
                r.op_a = pick_operand();
            else
                r.op_b = pick_operand();
        end
        else if (kind < 40)
        begin
            // rotation around the fold and wrap points
            r.cmd  = CMD_TO_RECT;
            r.op_b = pick_boundary_angle();
            if ($urandom_range(0, 2) == 0)
                r.op_a = pick_operand();
        end
        else if (kind < 55)
        begin
            r.op_a = pick_operand();
            r.op_b = pick_operand();
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, conv_req_t req, int expv, int actv);
        error_count++;
        $display("%0t: %s mismatch (cmd=%0d a=%0d b=%0d): expected %0d, actual %0d",
                 $time, what, req.cmd, req.op_a, req.op_b, expv, actv);
    endtask

    // Send one word; the sender runs in bursts separated by random gaps
    task automatic send_word(conv_req_t req, conv_result_t res);
        int gap;
        pending_t entry;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 :
                  int'($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 5));
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : int'($urandom_range(1, 40));
            if (gap > 0)
            begin
                // junk payload while idle
                req_ch.valid          <= 1'b0;
                req_ch.cmd            <= 1'($urandom());
                req_ch.first_operand  <= DATA_WIDTH'($urandom());
                req_ch.second_operand <= DATA_WIDTH'($urandom());
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid          <= 1'b1;
        req_ch.cmd            <= req.cmd;
        req_ch.first_operand  <= req.op_a;
        req_ch.second_operand <= req.op_b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        entry.req = req;
        entry.res = res;
        pending_results.insert(pending_results.size(), entry);
    endtask

    // Stimulus: reset, directed table, random words, drain
    initial
    begin : stimulus
        conv_req_t    req;
        conv_result_t res;
        error_count = 0;
        burst_left  = 0;
        rst_n                 <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.cmd            <= CMD_TO_POLAR;
        req_ch.first_operand  <= '0;
        req_ch.second_operand <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < DIRECTED_ROWS; n++)
        begin
            req.cmd  = directed_table[n].cmd;
            req.op_a = DATA_WIDTH'(directed_table[n].op_a);
            req.op_b = DATA_WIDTH'(directed_table[n].op_b);
            if (directed_table[n].typed)
            begin
                res.first_result  = RES_W'(directed_table[n].exp_first);
                res.second_result = DATA_WIDTH'(directed_table[n].exp_second);
            end
            else
                res = convert_word(req);
            send_word(req, res);
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            req = random_request();
            send_word(req, convert_word(req));
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: check each accepted word, stall on a mode-switching pattern
    initial
    begin : response_side
        pending_t entry;
        int stall_mode;
        int mode_left;
        int stall_left;
        stall_mode = 0;
        mode_left  = 0;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result word: expected none, actual %0d/%0d",
                             $time, rsp_ch.first_result, rsp_ch.second_result);
                end
                else
                begin
                    entry = pending_results.pop_front();
                    if (rsp_ch.first_result !== entry.res.first_result)
                        note_mismatch("first_result", entry.req, entry.res.first_result,
                                      rsp_ch.first_result);
                    if (rsp_ch.second_result !== entry.res.second_result)
                        note_mismatch("second_result", entry.req, entry.res.second_result,
                                      rsp_ch.second_result);
                end
            end

            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 400);
            end
            mode_left--;

            // mode 0: ready once a pending stall ends; 1: coin flip; 2: rare long stalls
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_mode == 1)
                rsp_ch.ready <= 1'($urandom_range(0, 1));
            else if (stall_mode == 2 && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(4, 24);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Run limit, several times the slowest legal run
    initial
    begin : run_limit
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule
